// ===== hw/rtl/msnf_pkg.sv =====
`timescale 1ns / 1ps
package msnf_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int RAW_DEPTH = MAX_WIDTH + 1;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int PTR_W     = $clog2(RAW_DEPTH);
  localparam int PEND_W    = $clog2(MAX_WIDTH + 2);
  localparam int FW_W      = 11;
  localparam int FH_W      = 16;
  localparam int SMP_W     = 16;
  localparam int RAW_W     = SMP_W + 1;
  localparam int SUM_W     = 20;
  localparam int MAG_W     = 19;
  localparam int CNT_W     = 4;
  localparam int REC_K     = 24;
  localparam int REC_W     = REC_K + 1;
  localparam int PROD_W    = MAG_W + REC_W;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = FW_W'(1024);
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = FH_W'(1000);

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_e;

  typedef enum logic [0:0] {
    OP_SAMPLE = 1'b0,
    OP_DRAIN  = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_ACC3,
    ST_MUL,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic       accept;
    logic       init_acc;
    logic [1:0] rd_sel;
    logic       acc_en;
    logic [1:0] acc_sel;
    logic       mul_en;
    logic       finish;
    logic       store;
  } dp_cmd_t;

  typedef struct packed {
    logic is_drain;
    logic drain_ok;
    logic emit_ok;
    logic out_free;
  } dp_sts_t;

  // ceil(2^REC_K / c); exact floor division for |sum| < 2^MAG_W
  function automatic logic [REC_W-1:0] recip(input logic [CNT_W-1:0] c);
    logic [REC_W-1:0] r;
    case (c)
      4'd1:    r = REC_W'((2**REC_K + 0) / 1);
      4'd2:    r = REC_W'((2**REC_K + 1) / 2);
      4'd3:    r = REC_W'((2**REC_K + 2) / 3);
      4'd4:    r = REC_W'((2**REC_K + 3) / 4);
      4'd5:    r = REC_W'((2**REC_K + 4) / 5);
      4'd6:    r = REC_W'((2**REC_K + 5) / 6);
      4'd7:    r = REC_W'((2**REC_K + 6) / 7);
      4'd8:    r = REC_W'((2**REC_K + 7) / 8);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/msnf_if.sv =====
`timescale 1ns / 1ps
interface msnf_in_if;
  import msnf_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    operation;
  logic signed [SMP_W-1:0] sample_value;
  logic                    sample_missing;
  modport source (output valid, operation, sample_value, sample_missing, input ready);
  modport sink   (input valid, operation, sample_value, sample_missing, output ready);
endinterface

interface msnf_out_if;
  import msnf_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [SMP_W-1:0] filled_value;
  logic                    was_filled;
  logic                    end_of_frame;
  modport source (output valid, filled_value, was_filled, end_of_frame, input ready);
  modport sink   (input valid, filled_value, was_filled, end_of_frame, output ready);
endinterface

// ===== hw/rtl/msnf_ram.sv =====
`timescale 1ns / 1ps
module msnf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== hw/rtl/msnf_cfg.sv =====
`timescale 1ns / 1ps
module msnf_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [msnf_pkg::ADDR_W-1:0]    paddr,
  input  logic [msnf_pkg::DATA_W-1:0]    pwdata,
  output logic [msnf_pkg::DATA_W-1:0]    prdata,
  output logic                           pready,
  output logic [msnf_pkg::PTR_W-1:0]     weff_o,
  output logic [msnf_pkg::FH_W-1:0]      heff_o,
  output logic                           restart_o
);
  import msnf_pkg::*;

  logic [FW_W-1:0] width_q;
  logic [FH_W-1:0] height_q;
  reg_idx_e        idx;
  logic            wr;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[2]);
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= FRAME_WIDTH_RST;
      height_q <= FRAME_HEIGHT_RST;
    end else if (wr) begin
      case (idx)
        REG_FRAME_WIDTH:  width_q  <= pwdata[FW_W-1:0];
        REG_FRAME_HEIGHT: height_q <= pwdata[FH_W-1:0];
        default: ;
      endcase
    end
  end

  // both decoded indexes are real registers, so any write restarts
  assign restart_o = wr;

  always_comb begin
    case (idx)
      REG_FRAME_WIDTH:  prdata = DATA_W'(width_q);
      REG_FRAME_HEIGHT: prdata = DATA_W'(height_q);
      default:          prdata = '0;
    endcase
  end

  always_comb begin
    if (width_q == '0) begin
      weff_o = PTR_W'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      weff_o = PTR_W'(MAX_WIDTH);
    end else begin
      weff_o = PTR_W'(width_q);
    end
  end

  assign heff_o = (height_q == '0) ? FH_W'(1) : height_q;
endmodule

// ===== hw/rtl/msnf_ctrl.sv =====
`timescale 1ns / 1ps
module msnf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  msnf_pkg::dp_sts_t sts_i,
  output msnf_pkg::dp_cmd_t cmd_o
);
  import msnf_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_PREP;
      ST_PREP: begin
        if (sts_i.is_drain) begin
          state_d = sts_i.drain_ok ? ST_RD0 : ST_IDLE;
        end else begin
          state_d = sts_i.emit_ok ? ST_RD0 : ST_IDLE;
        end
      end
      ST_RD0:  state_d = ST_RD1;
      ST_RD1:  state_d = ST_RD2;
      ST_RD2:  state_d = ST_RD3;
      ST_RD3:  state_d = ST_ACC3;
      ST_ACC3: state_d = ST_MUL;
      ST_MUL:  state_d = ST_FIN;
      ST_FIN:  if (sts_i.out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_PREP: begin
        if (sts_i.is_drain) begin
          cmd_o.init_acc = sts_i.drain_ok;
        end else begin
          cmd_o.init_acc = sts_i.emit_ok;
          cmd_o.store    = !sts_i.emit_ok;
        end
      end
      ST_RD0: cmd_o.rd_sel = 2'd0;
      ST_RD1: begin
        cmd_o.rd_sel  = 2'd1;
        cmd_o.acc_en  = 1'b1;
        cmd_o.acc_sel = 2'd0;
      end
      ST_RD2: begin
        cmd_o.rd_sel  = 2'd2;
        cmd_o.acc_en  = 1'b1;
        cmd_o.acc_sel = 2'd1;
      end
      ST_RD3: begin
        cmd_o.rd_sel  = 2'd3;
        cmd_o.acc_en  = 1'b1;
        cmd_o.acc_sel = 2'd2;
      end
      ST_ACC3: begin
        cmd_o.acc_en  = 1'b1;
        cmd_o.acc_sel = 2'd3;
      end
      ST_MUL:  cmd_o.mul_en = 1'b1;
      ST_FIN:  cmd_o.finish = sts_i.out_free;
      default: ;
    endcase
  end
endmodule

// ===== hw/rtl/msnf_datapath.sv =====
`timescale 1ns / 1ps
module msnf_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [msnf_pkg::PTR_W-1:0]          weff_i,
  input  logic [msnf_pkg::FH_W-1:0]           heff_i,
  input  logic                                restart_i,
  input  msnf_pkg::dp_cmd_t                   cmd_i,
  output msnf_pkg::dp_sts_t                   sts_o,
  input  logic                                operation_i,
  input  logic signed [msnf_pkg::SMP_W-1:0]   sample_value_i,
  input  logic                                sample_missing_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [msnf_pkg::SMP_W-1:0]   filled_value_o,
  output logic                                was_filled_o,
  output logic                                end_of_frame_o
);
  import msnf_pkg::*;

  op_e                op_q;
  logic [RAW_W-1:0]   word_q;
  logic [PTR_W-1:0]   wp_q, ep_q;
  logic [COL_W-1:0]   col_q, ej_q;
  logic [FH_W-1:0]    row_q, ei_q;
  logic               done_q;
  logic [PEND_W-1:0]  pend_q;
  logic [SMP_W-1:0]   ul_q, ul_next_q;
  logic [RAW_W-1:0]   self_q;
  logic signed [SUM_W-1:0] sum_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [PROD_W-1:0]  prod_q;
  logic               neg_q;
  logic               out_valid_q;
  logic [SMP_W-1:0]   out_val_q;
  logic               out_fill_q, out_eof_q;

  logic               up, left, right, below, restart;
  logic [PTR_W-1:0]   raw_raddr, ep_next, wp_next;
  logic [COL_W-1:0]   fil_raddr;
  logic [RAW_W-1:0]   raw_rdata;
  logic [SMP_W-1:0]   fil_rdata;
  logic               raw_we;
  logic               add_r, add_f;
  logic signed [SUM_W-1:0] term_r, term_f, init_a, init_b;
  logic [MAG_W-1:0]   mag, quo, mean;
  logic [SMP_W-1:0]   value;
  logic               last_col, last_row, last_ecol, last_erow;

  assign up     = ei_q != '0;
  assign left   = ej_q != '0;
  assign right  = (32'(ej_q) + 1) != 32'(weff_i);
  assign below  = (32'(ei_q) + 1) != 32'(heff_i);
  assign restart = restart_i || (cmd_i.accept && !operation_i && done_q);

  assign last_col  = (32'(col_q) + 1) == 32'(weff_i);
  assign last_row  = (32'(row_q) + 1) == 32'(heff_i);
  assign last_ecol = right == 1'b0;
  assign last_erow = below == 1'b0;

  assign ep_next = (ep_q == weff_i) ? '0 : ep_q + PTR_W'(1);
  assign wp_next = (wp_q == weff_i) ? '0 : wp_q + PTR_W'(1);

  // circular window of w+1 raw words: self, right, below-left, below
  always_comb begin
    case (cmd_i.rd_sel)
      2'd0: raw_raddr = ep_q;
      2'd1: raw_raddr = ep_next;
      2'd2: begin
        if (ep_q == '0) raw_raddr = weff_i - PTR_W'(1);
        else if (ep_q == PTR_W'(1)) raw_raddr = weff_i;
        else raw_raddr = ep_q - PTR_W'(2);
      end
      default: raw_raddr = (ep_q == '0) ? weff_i : ep_q - PTR_W'(1);
    endcase
  end

  always_comb begin
    case (cmd_i.rd_sel)
      2'd0:    fil_raddr = left ? ej_q - COL_W'(1) : ej_q;
      2'd2:    fil_raddr = right ? ej_q + COL_W'(1) : ej_q;
      default: fil_raddr = ej_q;
    endcase
  end

  assign raw_we = cmd_i.store || (cmd_i.finish && op_q == OP_SAMPLE);

  msnf_ram #(.WIDTH(RAW_W), .DEPTH(RAW_DEPTH)) u_raw_ram (
    .clk_i   (clk_i),
    .we_i    (raw_we),
    .waddr_i (wp_q),
    .wdata_i (word_q),
    .raddr_i (raw_raddr),
    .rdata_o (raw_rdata)
  );

  msnf_ram #(.WIDTH(SMP_W), .DEPTH(MAX_WIDTH)) u_fil_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.finish),
    .waddr_i (ej_q),
    .wdata_i (value),
    .raddr_i (fil_raddr),
    .rdata_o (fil_rdata)
  );

  always_comb begin
    add_r = 1'b0;
    add_f = 1'b0;
    case (cmd_i.acc_sel)
      2'd0: add_f = left;
      2'd1: begin
        add_r = right && !raw_rdata[SMP_W];
        add_f = up;
      end
      2'd2: begin
        add_r = below && left && !raw_rdata[SMP_W];
        add_f = up && right;
      end
      default: add_r = below && !raw_rdata[SMP_W];
    endcase
  end

  assign term_r = add_r ? SUM_W'(signed'(raw_rdata[SMP_W-1:0])) : '0;
  assign term_f = add_f ? SUM_W'(signed'(fil_rdata)) : '0;
  assign init_a = (up && left) ? SUM_W'(signed'(ul_q)) : '0;
  assign init_b = (op_q == OP_SAMPLE && below && right && !word_q[SMP_W])
                  ? SUM_W'(signed'(word_q[SMP_W-1:0])) : '0;

  assign mag  = sum_q[SUM_W-1] ? MAG_W'(-sum_q) : MAG_W'(sum_q);
  assign quo  = prod_q[REC_K +: MAG_W];
  assign mean = neg_q ? -quo : quo;
  assign value = self_q[SMP_W] ? mean[SMP_W-1:0] : self_q[SMP_W-1:0];

  // arithmetic registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q   <= op_e'(operation_i);
      word_q <= sample_missing_i ? {1'b1, {SMP_W{1'b0}}} : {1'b0, sample_value_i};
    end
    if (cmd_i.init_acc) begin
      sum_q <= init_a + init_b;
      cnt_q <= CNT_W'(up && left) + CNT_W'(init_b != '0 ||
               (op_q == OP_SAMPLE && below && right && !word_q[SMP_W]));
    end else if (cmd_i.acc_en) begin
      sum_q <= sum_q + term_r + term_f;
      cnt_q <= cnt_q + CNT_W'(add_r) + CNT_W'(add_f);
    end
    if (cmd_i.acc_en && cmd_i.acc_sel == 2'd0) self_q <= raw_rdata;
    if (cmd_i.acc_en && cmd_i.acc_sel == 2'd1) ul_next_q <= fil_rdata;
    if (cmd_i.mul_en) begin
      prod_q <= PROD_W'(mag) * PROD_W'(recip(cnt_q));
      neg_q  <= sum_q[SUM_W-1];
    end
    if (cmd_i.finish) begin
      out_val_q  <= value;
      out_fill_q <= self_q[SMP_W];
      out_eof_q  <= last_erow && last_ecol;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      ep_q   <= '0;
      col_q  <= '0;
      ej_q   <= '0;
      row_q  <= '0;
      ei_q   <= '0;
      done_q <= 1'b0;
      pend_q <= '0;
      ul_q   <= '0;
    end else if (restart) begin
      wp_q   <= '0;
      ep_q   <= '0;
      col_q  <= '0;
      ej_q   <= '0;
      row_q  <= '0;
      ei_q   <= '0;
      done_q <= 1'b0;
      pend_q <= '0;
      ul_q   <= '0;
    end else begin
      if (raw_we) begin
        wp_q <= wp_next;
        if (last_col) begin
          col_q <= '0;
          if (last_row) begin
            done_q <= 1'b1;
            pend_q <= (heff_i == FH_W'(1)) ? PEND_W'(weff_i) : PEND_W'(weff_i) + PEND_W'(1);
          end else begin
            row_q <= row_q + FH_W'(1);
          end
        end else begin
          col_q <= col_q + COL_W'(1);
        end
      end
      if (cmd_i.finish) begin
        ul_q <= ul_next_q;
        ep_q <= ep_next;
        if (last_ecol) begin
          ej_q <= '0;
          ei_q <= ei_q + FH_W'(1);
        end else begin
          ej_q <= ej_q + COL_W'(1);
        end
        if (op_q == OP_DRAIN) pend_q <= pend_q - PEND_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.is_drain = op_q == OP_DRAIN;
  assign sts_o.drain_ok = done_q && pend_q != '0;
  assign sts_o.emit_ok  = (row_q > FH_W'(1)) || (row_q == FH_W'(1) && col_q != '0);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign filled_value_o = out_val_q;
  assign was_filled_o   = out_fill_q;
  assign end_of_frame_o = out_eof_q;
endmodule

// ===== hw/rtl/missing_sample_neighbor_fill.sv =====
`timescale 1ns / 1ps
// Missing-sample fill over a 3x3 neighborhood, raster order in, raster order out.
// in_i carries one beat per sample (operation 0) or per drain step (operation 1).
// A missing sample is replaced by the truncated mean of its valid in-frame
// neighbors; samples above and to the left count with their filled values.
// The result for sample k leaves on out_o when sample k + W + 1 is taken; the
// last W + 1 results of a frame (W for a one-row frame) come out on drain beats.
// Beats are taken one at a time: a sample that yields no result is only stored;
// a beat that yields a result walks the controller through four reads of the
// raw window RAM, the accumulate, the reciprocal multiply and the write back.
// The result is registered and shows on out_o in the cycle after the write back.
// If out_o stalls, the finished result waits in the output register and the
// next beat can be taken; a later result waits in the final step until free.
// Configuration (frame_width at 0x0, frame_height at 0x4) is written over APB by
// the user only while idle, unchecked by the block; any write restarts the frame
// and drops pending results. Reset restores 1024 x 1000 and clears positions;
// the RAMs are not cleared, entries are always written before results read them.
module missing_sample_neighbor_fill (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  msnf_in_if.sink                     in_i,
  msnf_out_if.source                  out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [msnf_pkg::ADDR_W-1:0] paddr,
  input  logic [msnf_pkg::DATA_W-1:0] pwdata,
  output logic [msnf_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import msnf_pkg::*;

  logic [PTR_W-1:0] weff;
  logic [FH_W-1:0]  heff;
  logic             restart;
  dp_cmd_t          cmd;
  dp_sts_t          sts;
  logic             in_ready;

  msnf_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .weff_o    (weff),
    .heff_o    (heff),
    .restart_o (restart)
  );

  msnf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  assign in_i.ready = in_ready;

  msnf_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .weff_i           (weff),
    .heff_i           (heff),
    .restart_i        (restart),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .operation_i      (in_i.operation),
    .sample_value_i   (in_i.sample_value),
    .sample_missing_i (in_i.sample_missing),
    .out_valid_o      (out_o.valid),
    .out_ready_i      (out_o.ready),
    .filled_value_o   (out_o.filled_value),
    .was_filled_o     (out_o.was_filled),
    .end_of_frame_o   (out_o.end_of_frame)
  );
endmodule
